/* rtl/assert_macros.svh */
// Assertion macros for the velocity integrator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/tcvi_pkg.sv */
// ----------------------------------------------------------------------------
// tcvi_pkg
// Shared types and constants for the tilt-corrected velocity integrator.
// ----------------------------------------------------------------------------
package tcvi_pkg;
    localparam int CFG_FRAC_BITS = 24;
    localparam int ST_FRAC_BITS  = 32;
    localparam int CFG_W   = 24;
    localparam int STATE_W = 48;

    localparam logic [1:0] REG_AVG_RATE  = 2'd0;
    localparam logic [1:0] REG_LEAK_RATE = 2'd1;
    localparam logic [1:0] REG_STEP_TIME = 2'd2;

    localparam logic [23:0] AVG_RATE_RST  = 24'd1678;
    localparam logic [23:0] LEAK_RATE_RST = 24'd67109;
    localparam logic [23:0] STEP_TIME_RST = 24'd167772;

    typedef enum logic [2:0] {
        CMD_NONE, CMD_MATRIX, CMD_ROTATE, CMD_AVG, CMD_VEL, CMD_OUT
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] idx;
    } t_ctrl;

    typedef struct packed {
        logic       op;
        logic [15:0] comp_w;
        logic [15:0] comp_x;
        logic [15:0] comp_y;
        logic [15:0] comp_z;
        logic [31:0] time_ms;
    } t_in;

    typedef struct packed {
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [15:0] acc_x;
        logic [15:0] acc_y;
        logic [15:0] acc_z;
        logic [31:0] stamp_ms;
    } t_out;
endpackage

/* rtl/tcvi_stream_if.sv */
// ----------------------------------------------------------------------------
// tcvi_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface tcvi_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/tilt_corrected_velocity_integrator_top.sv */
// ----------------------------------------------------------------------------
// tilt_corrected_velocity_integrator_top
// Quaternion tilt correction with leaky velocity integration.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_if    in   op, comp_w..comp_z, time_ms
// out_if   out  vel_x..z, acc_x..z, stamp_ms
// cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data
// An event that completes no pair returns to idle after the pair check; one
// that completes a pair runs the shared step sequencer, then waits for output.
// A new transaction is accepted in the cycle the result is taken.
// Reset is synchronous and restores all but the matrix, acc, output and stamp.
`include "assert_macros.svh"
module tilt_corrected_velocity_integrator_top import tcvi_pkg::*; #(
    parameter int CONFIG_FRAC_BITS = CFG_FRAC_BITS,
    parameter int STATE_FRAC_BITS  = ST_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcvi_stream_if.sink   in_if,
    tcvi_stream_if.source out_if,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);
    logic [23:0] r_avg_rate, r_leak_rate, r_step_time;
    logic  load, pair;
    t_ctrl ctrl;
    t_out  res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_rate  <= AVG_RATE_RST;
            r_leak_rate <= LEAK_RATE_RST;
            r_step_time <= STEP_TIME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_AVG_RATE:  r_avg_rate  <= i_cfg_data;
                REG_LEAK_RATE: r_leak_rate <= i_cfg_data;
                REG_STEP_TIME: r_step_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcvi_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(in_if.valid),
        .o_in_ready(in_if.ready), .o_load(load), .i_pair(pair), .o_ctrl(ctrl),
        .o_out_valid(out_if.valid), .i_out_ready(out_if.ready)
    );

    tcvi_datapath #(.CONFIG_FRAC_BITS(CONFIG_FRAC_BITS),
                    .STATE_FRAC_BITS(STATE_FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(load), .i_item(in_if.data),
        .i_ctrl(ctrl), .i_avg_rate(r_avg_rate), .i_leak_rate(r_leak_rate),
        .i_step_time(r_step_time), .o_pair(pair), .o_result(res)
    );

    assign out_if.data = res;

    `ASSERT_NEVER(a_busy_no_out, i_clk, i_rst_n, out_if.valid && ctrl.cmd != CMD_NONE, "busy")
    `ASSERT_IMPL(a_hold, i_clk, i_rst_n, out_if.valid && !out_if.ready |=> $stable(res), "hold")
endmodule

/* rtl/tcvi_datapath.sv */
// ----------------------------------------------------------------------------
// tcvi_datapath
// Stores, multipliers and update arithmetic for the integrator.
// ----------------------------------------------------------------------------
module tcvi_datapath import tcvi_pkg::*; #(
    parameter int CONFIG_FRAC_BITS = CFG_FRAC_BITS,
    parameter int STATE_FRAC_BITS  = ST_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_in         i_item,
    input  t_ctrl       i_ctrl,
    input  logic [23:0] i_avg_rate,
    input  logic [23:0] i_leak_rate,
    input  logic [23:0] i_step_time,
    output logic        o_pair,
    output t_out        o_result
);
    localparam int SW = STATE_W;

    logic signed [15:0] r_q [4];
    logic signed [15:0] r_a [3];
    logic               r_qf, r_af;
    logic signed [35:0] r_m [9];
    logic signed [15:0] r_acc [3];
    logic signed [SW-1:0] r_avg [3];
    logic signed [SW-1:0] r_vel [3];
    logic signed [31:0] r_vo [3];
    logic [31:0]        r_stamp;

    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        return (v == 16'sh8000) ? 16'sh7fff : -v;
    endfunction

    function automatic logic signed [SW-1:0] sat48(input logic signed [SW+1:0] v);
        logic signed [SW+1:0] hi, lo;
        hi = (SW+2)'({1'b0, {(SW-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi) return hi[SW-1:0];
        if (v < lo) return lo[SW-1:0];
        return v[SW-1:0];
    endfunction

    // round(a*b/2^CONFIG_FRAC_BITS) ties away, a magnitude up to 49 bits
    function automatic logic signed [SW+1:0] mulf(input logic signed [SW:0] a,
                                                  input logic [23:0] b);
        logic [SW:0]   m;
        logic [SW+24:0] p;
        logic [SW+24:0] r;
        m = a[SW] ? -a : a;
        p = (SW+25)'(m) * (SW+25)'(b);
        r = (p + ((SW+25)'(1) << (CONFIG_FRAC_BITS-1))) >> CONFIG_FRAC_BITS;
        return a[SW] ? -(SW+2)'(r) : (SW+2)'(r);
    endfunction

    logic signed [15:0] w, x, y, z;
    logic signed [35:0] one;
    logic [3:0] ii;
    logic [1:0] ax;
    logic signed [SW:0] wide, dif;
    logic signed [SW+1:0] na, nv;
    logic signed [63:0] sum, rr;
    logic [63:0] mg;
    assign w = r_q[0]; assign x = r_q[1]; assign y = r_q[2]; assign z = r_q[3];
    assign one = 36'sd1 <<< 28;
    assign ii = i_ctrl.idx;
    assign ax = ii[1:0];

    always_comb begin
        sum = 64'(r_m[3*ax]) * 64'(r_a[0]) + 64'(r_m[3*ax+1]) * 64'(r_a[1])
            + 64'(r_m[3*ax+2]) * 64'(r_a[2]);
        mg = sum[63] ? -sum : sum;
        mg = (mg + (64'd1 << 27)) >> 28;
        rr = sum[63] ? -$signed(mg) : $signed(mg);
        wide = (SW+1)'($signed(sat48((SW+2)'(r_acc[ax]) <<< (STATE_FRAC_BITS-8))));
        dif = wide - (SW+1)'(r_avg[ax]);
        na = (SW+2)'(r_avg[ax]) + mulf(dif, i_avg_rate);
        nv = (SW+2)'(r_vel[ax]) + mulf(dif, i_step_time)
           - mulf((SW+1)'(r_vel[ax]), i_leak_rate);
    end

    function automatic logic signed [31:0] vround(input logic signed [SW-1:0] v);
        logic [SW-1:0] m;
        logic signed [SW:0] s;
        m = v[SW-1] ? -v : v;
        m = (m + (SW'(1) << (STATE_FRAC_BITS-17))) >> (STATE_FRAC_BITS-16);
        s = v[SW-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
        if (s > (SW+1)'(64'sd2147483647)) return 32'sh7fffffff;
        if (s < -(SW+1)'(64'sd2147483648)) return 32'sh80000000;
        return s[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q[0] <= 16'sd16384; r_q[1] <= '0; r_q[2] <= '0; r_q[3] <= '0;
            for (int k = 0; k < 3; k++) begin
                r_a[k] <= '0; r_avg[k] <= '0; r_vel[k] <= '0;
            end
            r_qf <= 1'b0; r_af <= 1'b0;
        end else begin
            if (i_load) begin
                r_stamp <= i_item.time_ms;
                if (i_item.op) begin
                    r_a[0] <= i_item.comp_x; r_a[1] <= i_item.comp_y;
                    r_a[2] <= i_item.comp_z; r_af <= 1'b1;
                end else begin
                    r_q[0] <= i_item.comp_w;
                    r_q[1] <= neg_sat(i_item.comp_x);
                    r_q[2] <= neg_sat(i_item.comp_y);
                    r_q[3] <= neg_sat(i_item.comp_z);
                    r_qf <= 1'b1;
                end
            end
            unique case (i_ctrl.cmd)
                CMD_MATRIX: begin
                    r_m[0] <= one - 36'sd2 * (36'(y) * y + 36'(z) * z);
                    r_m[1] <= 36'sd2 * (36'(x) * y + 36'(w) * z);
                    r_m[2] <= 36'sd2 * (36'(x) * z - 36'(w) * y);
                    r_m[3] <= 36'sd2 * (36'(x) * y - 36'(w) * z);
                    r_m[4] <= one - 36'sd2 * (36'(x) * x + 36'(z) * z);
                    r_m[5] <= 36'sd2 * (36'(y) * z + 36'(w) * x);
                    r_m[6] <= 36'sd2 * (36'(x) * z + 36'(w) * y);
                    r_m[7] <= 36'sd2 * (36'(y) * z - 36'(w) * x);
                    r_m[8] <= one - 36'sd2 * (36'(x) * x + 36'(y) * y);
                end
                CMD_ROTATE: r_acc[ax] <= (rr > 32767) ? 16'sh7fff :
                                        (rr < -32768) ? 16'sh8000 : rr[15:0];
                CMD_AVG: r_avg[ax] <= sat48(na);
                CMD_VEL: r_vel[ax] <= sat48(nv);
                CMD_OUT: begin
                    r_vo[ax] <= vround(r_vel[ax]);
                    r_qf <= 1'b0; r_af <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_pair = r_qf && r_af;
    assign o_result = '{vel_x: r_vo[0], vel_y: r_vo[1], vel_z: r_vo[2],
                        acc_x: r_acc[0], acc_y: r_acc[1], acc_z: r_acc[2],
                        stamp_ms: r_stamp};
endmodule

/* rtl/tcvi_ctrl.sv */
// ----------------------------------------------------------------------------
// tcvi_ctrl
// Sequencer for one transaction: matrix, rotate, average, velocity, output.
// ----------------------------------------------------------------------------
module tcvi_ctrl import tcvi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_load,
    input  logic  i_pair,
    output t_ctrl o_ctrl,
    output logic  o_out_valid,
    input  logic  i_out_ready
);
    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_RUN, S_DONE} t_state;
    t_state     r_state;
    logic [3:0] r_step;

    assign o_in_ready = (r_state == S_IDLE) || (r_state == S_DONE && i_out_ready);
    assign o_load = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_DONE);

    always_comb begin
        o_ctrl.cmd = CMD_NONE;
        o_ctrl.idx = '0;
        if (r_state == S_RUN) begin
            if (r_step == 4'd0) o_ctrl.cmd = CMD_MATRIX;
            else if (r_step < 4'd4) begin
                o_ctrl.cmd = CMD_ROTATE; o_ctrl.idx = r_step - 4'd1;
            end else if (r_step < 4'd7) begin
                o_ctrl.cmd = CMD_AVG; o_ctrl.idx = r_step - 4'd4;
            end else if (r_step < 4'd10) begin
                o_ctrl.cmd = CMD_VEL; o_ctrl.idx = r_step - 4'd7;
            end else begin
                o_ctrl.cmd = CMD_OUT; o_ctrl.idx = r_step - 4'd10;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (o_load) r_state <= S_CHECK;
                S_CHECK: begin
                    r_step <= '0;
                    r_state <= i_pair ? S_RUN : S_IDLE;
                end
                S_RUN: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd12) r_state <= S_DONE;
                end
                S_DONE: if (i_out_ready) r_state <= o_load ? S_CHECK : S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
